// File: hw/rtl/sleb128_stack_map_record_decoder_defines.svh
// assertion macros for the stack-map record decoder checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SLEB128_STACK_MAP_RECORD_DECODER_DEFINES_SVH
`define SLEB128_STACK_MAP_RECORD_DECODER_DEFINES_SVH

// same-cycle implication
`define SLEBSM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLEBSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/slebsm_pkg.sv
// shared constants and types for the stack-map record decoder
// no dependencies
package slebsm_pkg;

  typedef enum logic [2:0] {
    KIND_VREG  = 3'd0,
    KIND_REG   = 3'd1,
    KIND_STACK = 3'd2,
    KIND_IMM   = 3'd3,
    KIND_LARGE = 3'd4,
    KIND_ERROR = 3'd5
  } entry_kind_t;

  typedef enum logic [1:0] {
    CLASS_IMM   = 2'd0,
    CLASS_REG   = 2'd1,
    CLASS_STACK = 2'd2
  } kind_class_t;

  typedef enum logic [1:0] {
    ROLE_VREG  = 2'd0,
    ROLE_KIND  = 2'd1,
    ROLE_VALUE = 2'd2
  } field_role_t;

  localparam logic       CFG_FRAME_PTR_REG = 1'b0;
  localparam logic       CFG_RECORD_FORMAT = 1'b1;
  localparam int         CFG_DATA_W        = 16;

  localparam logic [6:0] LEB_GROUP_BITS    = 7'd7;
  localparam logic [6:0] SHIFT_SAT         = 7'd70;
  localparam logic [7:0] LEB_CONT_MASK     = 8'h80;
  localparam logic [7:0] LEB_SIGN_MASK     = 8'h40;
  localparam logic [7:0] LEB_DATA_MASK     = 8'h7f;
  localparam logic [15:0] DWARF_REG_SLOT   = 16'hFFFF;

  localparam logic [63:0] KIND_CODE_REG    = 64'd2;
  localparam logic [63:0] KIND_CODE_STACK  = 64'd1;

endpackage

// File: hw/rtl/slebsm_in_if.sv
// input byte channel of the stack-map record decoder
// no dependencies
interface slebsm_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [63:0] record_pc;
  logic        end_of_record;

  modport source (output valid, data_byte, record_pc, end_of_record, input ready);
  modport sink   (input valid, data_byte, record_pc, end_of_record, output ready);
endinterface

// File: hw/rtl/slebsm_out_if.sv
// result entry channel of the stack-map record decoder
// no dependencies
interface slebsm_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         entry_kind;
  logic [15:0]        dwarf_reg;
  logic signed [63:0] entry_value;
  logic [63:0]        entry_pc;
  logic               last_of_record;

  modport source (output valid, entry_kind, dwarf_reg, entry_value, entry_pc,
                  last_of_record, input ready);
  modport sink   (input valid, entry_kind, dwarf_reg, entry_value, entry_pc,
                  last_of_record, output ready);
endinterface

// File: hw/rtl/sleb128_stack_map_record_decoder.sv
// signed leb128 stack-map record decoder, top level
// depends on slebsm_pkg, slebsm_in_if, slebsm_out_if
//
// channel  | dir | handshake     | payload
// ---------+-----+---------------+---------------------------------------------
// in_ch    | in  | valid/ready   | data_byte, record_pc, end_of_record
// out_ch   | out | valid/ready   | entry_kind, dwarf_reg, entry_value, entry_pc,
//          |     |               | last_of_record
// cfg      | in  | cfg_we only   | cfg_index, cfg_data
//
// one byte a cycle sustained while a byte that yields a result is not held by a stalled out_ch
// byte sits in an input register, decode state and result register update together
// a stalled result holds only bytes that would produce a further result
// synchronous active-low reset clears decode state, config and both valids
module sleb128_stack_map_record_decoder
  import slebsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  slebsm_in_if.sink             in_ch,
  slebsm_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] fp_reg_r;
  logic        fmt_r;

  logic        in_v_r;
  logic [7:0]  byte_r;
  logic [63:0] pc_r;
  logic        eor_r;

  logic [63:0] acc_r, acc_nxt;
  logic [6:0]  shift_r, shift_nxt;
  logic [1:0]  pos_r, pos_nxt;
  kind_class_t cls_r, cls_nxt;
  logic        disc_r, disc_nxt;

  logic        emit;
  entry_kind_t res_kind;
  logic [15:0] res_reg;
  logic [63:0] res_val;
  logic        res_last;

  logic        out_v_r;
  entry_kind_t out_kind_r;
  logic [15:0] out_reg_r;
  logic [63:0] out_val_r;
  logic [63:0] out_pc_r;
  logic        out_last_r;

  logic        out_free;
  logic        adv;

  assign out_free    = !out_v_r || out_ch.ready;
  assign adv         = in_v_r && (!emit || out_free);
  assign in_ch.ready = !in_v_r || adv;

  always_comb begin
    logic [63:0] shifted;
    logic [63:0] acc_or;
    logic [6:0]  shift_add;
    logic [6:0]  shift_sat;
    logic [63:0] fill;
    logic [63:0] v;
    logic [63:0] v_sx;
    field_role_t role;

    acc_nxt   = acc_r;
    shift_nxt = shift_r;
    pos_nxt   = pos_r;
    cls_nxt   = cls_r;
    disc_nxt  = disc_r;
    emit      = 1'b0;
    res_kind  = KIND_ERROR;
    res_reg   = 16'd0;
    res_val   = 64'd0;
    res_last  = 1'b1;

    shifted   = {56'd0, byte_r & LEB_DATA_MASK} << shift_r[5:0];
    acc_or    = shift_r[6] ? acc_r : (acc_r | shifted);
    shift_add = shift_r + LEB_GROUP_BITS;
    shift_sat = (shift_add > SHIFT_SAT) ? SHIFT_SAT : shift_add;
    fill      = (!shift_sat[6] && ((byte_r & LEB_SIGN_MASK) != 8'd0))
                ? ({64{1'b1}} << shift_sat[5:0]) : 64'd0;
    v         = acc_or | fill;
    v_sx      = {{32{v[31]}}, v[31:0]};

    if (fmt_r) begin
      role = (pos_r == 2'd0) ? ROLE_VREG : (pos_r == 2'd1) ? ROLE_KIND : ROLE_VALUE;
    end else begin
      role = (pos_r == 2'd0) ? ROLE_KIND : ROLE_VALUE;
    end

    if (disc_r) begin
      if (eor_r) begin
        emit      = 1'b1;
        acc_nxt   = 64'd0;
        shift_nxt = 7'd0;
        pos_nxt   = 2'd0;
        cls_nxt   = CLASS_IMM;
        disc_nxt  = 1'b0;
      end
    end else if ((byte_r & LEB_CONT_MASK) != 8'd0) begin
      if (eor_r) begin
        emit      = 1'b1;
        acc_nxt   = 64'd0;
        shift_nxt = 7'd0;
        pos_nxt   = 2'd0;
        cls_nxt   = CLASS_IMM;
      end else begin
        acc_nxt   = acc_or;
        shift_nxt = shift_sat;
      end
    end else begin
      acc_nxt   = 64'd0;
      shift_nxt = 7'd0;
      if (eor_r && role != ROLE_VALUE) begin
        emit    = 1'b1;
        pos_nxt = 2'd0;
        cls_nxt = CLASS_IMM;
      end else begin
        unique case (role)
          ROLE_VREG: begin
            pos_nxt  = 2'd1;
            emit     = 1'b1;
            res_kind = KIND_VREG;
            res_val  = v_sx;
            res_last = 1'b0;
          end
          ROLE_KIND: begin
            pos_nxt = fmt_r ? 2'd2 : 2'd1;
            if (v == KIND_CODE_REG) begin
              cls_nxt = CLASS_REG;
            end else if (v == KIND_CODE_STACK) begin
              cls_nxt = CLASS_STACK;
            end else if (!fmt_r) begin
              pos_nxt  = 2'd0;
              cls_nxt  = CLASS_IMM;
              disc_nxt = 1'b1;
            end else begin
              cls_nxt = CLASS_IMM;
            end
          end
          default: begin
            pos_nxt  = 2'd0;
            emit     = 1'b1;
            res_last = eor_r;
            if (eor_r) begin
              cls_nxt = CLASS_IMM;
            end
            unique case (cls_r)
              CLASS_REG: begin
                res_kind = KIND_REG;
                res_reg  = DWARF_REG_SLOT;
                res_val  = v_sx;
              end
              CLASS_STACK: begin
                res_kind = KIND_STACK;
                res_reg  = fp_reg_r;
                res_val  = v_sx;
              end
              default: begin
                res_kind = (v_sx == v) ? KIND_IMM : KIND_LARGE;
                res_val  = v;
              end
            endcase
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_reg_r <= 16'd0;
      fmt_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_PTR_REG: fp_reg_r <= cfg_data;
        CFG_RECORD_FORMAT: fmt_r    <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.data_byte;
      pc_r   <= in_ch.record_pc;
      eor_r  <= in_ch.end_of_record;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 64'd0;
      shift_r <= 7'd0;
      pos_r   <= 2'd0;
      cls_r   <= CLASS_IMM;
      disc_r  <= 1'b0;
    end else if (adv) begin
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      pos_r   <= pos_nxt;
      cls_r   <= cls_nxt;
      disc_r  <= disc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && emit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (adv && emit) begin
      out_kind_r <= res_kind;
      out_reg_r  <= res_reg;
      out_val_r  <= res_val;
      out_pc_r   <= pc_r;
      out_last_r <= res_last;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.entry_kind     = out_kind_r;
  assign out_ch.dwarf_reg      = out_reg_r;
  assign out_ch.entry_value    = out_val_r;
  assign out_ch.entry_pc       = out_pc_r;
  assign out_ch.last_of_record = out_last_r;

endmodule

// File: hw/rtl/slebsm_checker.sv
// port-level checker for the stack-map record decoder, with its bind
// depends on slebsm_pkg and sleb128_stack_map_record_decoder_defines.svh
`include "sleb128_stack_map_record_decoder_defines.svh"

module slebsm_checker
  import slebsm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         entry_kind,
  input logic [15:0]        dwarf_reg,
  input logic signed [63:0] entry_value,
  input logic               last_of_record
);

  `SLEBSM_ASSERT(a_err_last, out_valid && entry_kind == KIND_ERROR, last_of_record && entry_value == 64'sd0, "error entry must be last with zero value")
  `SLEBSM_ASSERT(a_reg_tag, out_valid && entry_kind == KIND_REG, dwarf_reg == DWARF_REG_SLOT, "register slot without 0xFFFF tag")
  `SLEBSM_ASSERT(a_imm_range, out_valid && entry_kind == KIND_IMM, entry_value[63:31] == {33{entry_value[31]}}, "immediate outside int32 range")
  `SLEBSM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(entry_value), "stalled result changed")

endmodule

bind sleb128_stack_map_record_decoder slebsm_checker u_slebsm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .entry_kind     (out_ch.entry_kind),
  .dwarf_reg      (out_ch.dwarf_reg),
  .entry_value    (out_ch.entry_value),
  .last_of_record (out_ch.last_of_record)
);
